// File: rtl/core/sps_pkg.sv
package sps_pkg;

   localparam int STORE_DEPTH_DEF = 4096;
   localparam int WORD_BITS_DEF   = 16;

   localparam int IN_W      = 16;  // input word port
   localparam int ROWS_W    = 12;  // row_count register
   localparam int ROW_CNT_W = 13;  // row cursor, reaches row_count itself
   localparam int STATUS_W  = 2;

   localparam logic [STATUS_W-1:0] ST_SYM    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONSYM = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

   typedef enum logic [2:0] {
      ASEL_ROW,
      ASEL_ROW_NEXT,
      ASEL_ENTRY,
      ASEL_RDATA,
      ASEL_COL_NEXT,
      ASEL_SEARCH
   } addr_sel_type;

   typedef struct packed {
      logic         store;       // write incoming word, bump load count
      logic         load_clr;
      addr_sel_type addr_sel;
      logic         row_clr;
      logic         row_inc;
      logic         prev_ld;
      logic         entry_ld;
      logic         entry_inc;
      logic         end_ld;
      logic         col_ld;
      logic         search_ld;
      logic         search_inc;
      logic         ce_ld;
   } cmd_type;

   typedef struct packed {
      logic size_bad;
      logic ptr_bad;
      logic row_eq_n;
      logic row_lt_n;
      logic entry_lt_end;
      logic col_le_row;
      logic col_ge_n;
      logic search_lt_ce;
      logic match;
   } flag_type;

endpackage

// File: rtl/core/sps_ram.sv
module sps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sps_datapath.sv
module sps_datapath #(
   parameter int STORE_DEPTH = sps_pkg::STORE_DEPTH_DEF,
   parameter int WORD_BITS   = sps_pkg::WORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [sps_pkg::ROWS_W-1:0]  csr_wr_data,
   input  logic [sps_pkg::IN_W-1:0]    req_index_word,
   input  sps_pkg::cmd_type            cmd,
   output sps_pkg::flag_type           flags
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 2);
   localparam int MAX_A  = (WORD_BITS > CNT_W) ? WORD_BITS : CNT_W;
   localparam int CMP_W  = ((MAX_A > sps_pkg::ROW_CNT_W) ? MAX_A : sps_pkg::ROW_CNT_W) + 1;

   logic [sps_pkg::ROWS_W-1:0]    row_count_ff;
   logic [CNT_W-1:0]              load_count_ff, load_count_in;
   logic [sps_pkg::ROW_CNT_W-1:0] row_ff, row_in;
   logic [WORD_BITS-1:0]          prev_ff, entry_ff, entry_in, end_ff, col_ff;
   logic [WORD_BITS-1:0]          search_ff, search_in, ce_ff;

   logic [31:0]          word_wide;
   logic [WORD_BITS-1:0] word;
   logic                 wr_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   logic [CMP_W-1:0] rdata_x, cnt_x, row_x, n_x, prev_x, col_x;

   assign word_wide = {{(32 - sps_pkg::IN_W){1'b0}}, req_index_word};
   assign word      = word_wide[WORD_BITS-1:0];
   assign wr_en     = cmd.store && (load_count_ff < CNT_W'(STORE_DEPTH));

   assign rdata_x = CMP_W'(rd_data);
   assign cnt_x   = CMP_W'(load_count_ff);
   assign row_x   = CMP_W'(row_ff);
   assign n_x     = CMP_W'(row_count_ff);
   assign prev_x  = CMP_W'(prev_ff);
   assign col_x   = CMP_W'(col_ff);

   // every address reached by the walk lies below the load count,
   // so truncation to the store's address width is exact
   always_comb begin
      unique case (cmd.addr_sel)
         sps_pkg::ASEL_ROW:      rd_addr = ADDR_W'(row_x);
         sps_pkg::ASEL_ROW_NEXT: rd_addr = ADDR_W'(row_x + CMP_W'(1));
         sps_pkg::ASEL_ENTRY:    rd_addr = ADDR_W'(CMP_W'(entry_ff));
         sps_pkg::ASEL_RDATA:    rd_addr = ADDR_W'(rdata_x);
         sps_pkg::ASEL_COL_NEXT: rd_addr = ADDR_W'(col_x + CMP_W'(1));
         sps_pkg::ASEL_SEARCH:   rd_addr = ADDR_W'(CMP_W'(search_ff));
         default:                rd_addr = '0;
      endcase
   end

   sps_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(load_count_ff)),
      .wr_data (word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      load_count_in = load_count_ff;
      if (cmd.load_clr) begin
         load_count_in = '0;
      end else if (cmd.store) begin
         if (wr_en) begin
            load_count_in = load_count_ff + CNT_W'(1);
         end else begin
            load_count_in = CNT_W'(STORE_DEPTH + 1);  // overrun marker
         end
      end

      row_in = row_ff;
      if (cmd.row_clr) begin
         row_in = '0;
      end else if (cmd.row_inc) begin
         row_in = row_ff + sps_pkg::ROW_CNT_W'(1);
      end

      entry_in = entry_ff;
      if (cmd.entry_ld) begin
         entry_in = rd_data;
      end else if (cmd.entry_inc) begin
         entry_in = entry_ff + WORD_BITS'(1);
      end

      search_in = search_ff;
      if (cmd.search_ld) begin
         search_in = rd_data;
      end else if (cmd.search_inc) begin
         search_in = search_ff + WORD_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= sps_pkg::ROWS_W'(1);
         load_count_ff <= '0;
         row_ff        <= '0;
         entry_ff      <= '0;
         search_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            row_count_ff <= csr_wr_data;
         end
         load_count_ff <= load_count_in;
         row_ff        <= row_in;
         entry_ff      <= entry_in;
         search_ff     <= search_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prev_ld) prev_ff <= rd_data;
      if (cmd.end_ld)  end_ff  <= rd_data;
      if (cmd.col_ld)  col_ff  <= rd_data;
      if (cmd.ce_ld)   ce_ff   <= rd_data;
   end

   always_comb begin
      flags.size_bad     = (load_count_ff > CNT_W'(STORE_DEPTH)) ||
                           (cnt_x < n_x + CMP_W'(1));
      flags.ptr_bad      = (rdata_x > cnt_x) || ((row_ff != '0) && (rdata_x < prev_x));
      flags.row_eq_n     = (row_x == n_x);
      flags.row_lt_n     = (row_x < n_x);
      flags.entry_lt_end = (entry_ff < end_ff);
      flags.col_le_row   = (rdata_x <= row_x);
      flags.col_ge_n     = (rdata_x >= n_x);
      flags.search_lt_ce = (search_ff < ce_ff);
      flags.match        = (rdata_x == row_x);
   end

endmodule

// File: rtl/core/sps_ctrl.sv
module sps_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_last_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sps_pkg::STATUS_W-1:0]  rsp_status,
   input  sps_pkg::flag_type             flags,
   output sps_pkg::cmd_type              cmd
);

   typedef enum logic [3:0] {
      LOAD,
      SIZE,
      PTR_RD,
      PTR_CHK,
      WALK_ROW,
      ROW_BEG,
      ROW_END,
      ENT_TEST,
      ENT_GET,
      COL_BEG,
      COL_END,
      SRCH_TEST,
      SRCH_GET,
      FINISH
   } state_type;

   state_type                     state_ff, state_in;
   logic [sps_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic                          rsp_valid_ff;
   logic [sps_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic                          accept;
   logic                          publish;

   assign req_stall  = (state_ff != LOAD);
   assign accept     = req_valid && !req_stall;
   assign publish    = (state_ff == FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      status_in = status_ff;
      unique case (state_ff)
         LOAD: begin
            cmd.store = accept;
            if (accept && req_last_word) state_in = SIZE;
         end
         SIZE: begin
            if (flags.size_bad) begin
               status_in = sps_pkg::ST_BAD;
               state_in  = FINISH;
            end else begin
               cmd.row_clr = 1'b1;
               state_in    = PTR_RD;
            end
         end
         PTR_RD: begin
            cmd.addr_sel = sps_pkg::ASEL_ROW;
            state_in     = PTR_CHK;
         end
         PTR_CHK: begin
            if (flags.ptr_bad) begin
               status_in = sps_pkg::ST_BAD;
               state_in  = FINISH;
            end else begin
               cmd.prev_ld = 1'b1;
               if (flags.row_eq_n) begin
                  cmd.row_clr = 1'b1;
                  state_in    = WALK_ROW;
               end else begin
                  cmd.row_inc = 1'b1;
                  state_in    = PTR_RD;
               end
            end
         end
         WALK_ROW: begin
            if (flags.row_lt_n) begin
               cmd.addr_sel = sps_pkg::ASEL_ROW;
               state_in     = ROW_BEG;
            end else begin
               status_in = sps_pkg::ST_SYM;
               state_in  = FINISH;
            end
         end
         ROW_BEG: begin
            cmd.entry_ld = 1'b1;
            cmd.addr_sel = sps_pkg::ASEL_ROW_NEXT;
            state_in     = ROW_END;
         end
         ROW_END: begin
            cmd.end_ld = 1'b1;
            state_in   = ENT_TEST;
         end
         ENT_TEST: begin
            if (flags.entry_lt_end) begin
               cmd.addr_sel = sps_pkg::ASEL_ENTRY;
               state_in     = ENT_GET;
            end else begin
               cmd.row_inc = 1'b1;
               state_in    = WALK_ROW;
            end
         end
         ENT_GET: begin
            cmd.col_ld = 1'b1;
            if (flags.col_le_row) begin
               cmd.entry_inc = 1'b1;
               state_in      = ENT_TEST;
            end else if (flags.col_ge_n) begin
               status_in = sps_pkg::ST_BAD;
               state_in  = FINISH;
            end else begin
               // column word on the read bus addresses its own row pointer
               cmd.addr_sel = sps_pkg::ASEL_RDATA;
               state_in     = COL_BEG;
            end
         end
         COL_BEG: begin
            cmd.search_ld = 1'b1;
            cmd.addr_sel  = sps_pkg::ASEL_COL_NEXT;
            state_in      = COL_END;
         end
         COL_END: begin
            cmd.ce_ld = 1'b1;
            state_in  = SRCH_TEST;
         end
         SRCH_TEST: begin
            if (flags.search_lt_ce) begin
               cmd.addr_sel = sps_pkg::ASEL_SEARCH;
               state_in     = SRCH_GET;
            end else begin
               status_in = sps_pkg::ST_NONSYM;
               state_in  = FINISH;
            end
         end
         SRCH_GET: begin
            if (flags.match) begin
               cmd.entry_inc = 1'b1;
               state_in      = ENT_TEST;
            end else begin
               cmd.search_inc = 1'b1;
               state_in       = SRCH_TEST;
            end
         end
         FINISH: begin
            if (publish) begin
               cmd.load_clr = 1'b1;
               state_in     = LOAD;
            end
         end
         default: state_in = LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      status_ff <= status_in;
      if (publish) rsp_status_ff <= status_ff;
   end

endmodule

// File: rtl/core/sparse_pattern_symmetry_check_top.sv
// Structural symmetry check of a sparse pattern in modified sparse row form. The index
// array streams in one word per cycle: row_count + 1 row start pointers, then the column
// numbers of the off-diagonal entries; only the low WORD_BITS bits of each word are kept.
// Words not marked last produce no transaction on the rsp side. After the word marked
// last, the input stalls while the pattern is checked, and one status comes out:
// 0 symmetric, 1 not symmetric, 2 malformed (store overrun, too few words, a pointer past
// the load, decreasing pointers, or a column at or beyond row_count). Check time is data
// dependent and bounded by the single read port of the index store, which reads each row
// pointer, then each row's bounds and stored entries, and for each entry above the diagonal
// scans the words of the mirrored row. row_count must only be written while no check
// is running.
module sparse_pattern_symmetry_check_top #(
   parameter int STORE_DEPTH = sps_pkg::STORE_DEPTH_DEF,
   parameter int WORD_BITS   = sps_pkg::WORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sps_pkg::ROWS_W-1:0]    csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sps_pkg::IN_W-1:0]      req_index_word,
   input  logic                          req_last_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sps_pkg::STATUS_W-1:0]  rsp_status
);

   sps_pkg::cmd_type  cmd;
   sps_pkg::flag_type flags;

   sps_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_last_word (req_last_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .flags         (flags),
      .cmd           (cmd)
   );

   sps_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .WORD_BITS   (WORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_index_word (req_index_word),
      .cmd            (cmd),
      .flags          (flags)
   );

endmodule

// File: verif/tb_sparse_pattern_symmetry_check_top.sv
module tb_sparse_pattern_symmetry_check_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  DEPTH          = sps_pkg::STORE_DEPTH_DEF;
   localparam int  RANDOM_WORDS   = 1350;
   localparam int  TAIL_CYCLES    = 16;
   localparam int  DRAIN_LIMIT    = 200000;
   localparam real RUN_LIMIT_NS   = 2_000_000.0;
   localparam int  MAX_PAT_ROWS   = 64;

   typedef enum int {
      LD_SYM,
      LD_ASYM,
      LD_COL_RANGE,
      LD_PTR_DEC,
      LD_PTR_PAST,
      LD_SHORT,
      LD_NOISE
   } load_kind_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [sps_pkg::ROWS_W-1:0]    csr_wr_data;
   logic                          req_valid;
   logic                          req_stall;
   logic [sps_pkg::IN_W-1:0]      req_index_word;
   logic                          req_last_word;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [sps_pkg::STATUS_W-1:0]  rsp_status;

   // predictor state
   logic [sps_pkg::IN_W-1:0]      pat_store [0:DEPTH-1];
   int unsigned                   pat_count;
   logic [sps_pkg::ROWS_W-1:0]    rows_cfg;
   logic [sps_pkg::STATUS_W-1:0]  status_q [$];

   // stimulus scratch
   logic [sps_pkg::IN_W-1:0]      load_q [$];
   bit                            link [0:MAX_PAT_ROWS-1][0:MAX_PAT_ROWS-1];

   bit                   send_idle;
   bit                   recv_idle;
   int                   hold_left;
   int                   err_count;
   int                   words_sent;
   int                   loads_sent;
   int                   row_writes;
   int                   seen_by_status [0:3];

   sparse_pattern_symmetry_check_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_index_word (req_index_word),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: timeout, %0d results still pending", $time, status_q.size());
      $display("tb_sparse_pattern_symmetry_check_top: done, errors");
      $finish;
   end

   // Walks the loaded pattern the same way the block does and returns its status.
   function automatic logic [sps_pkg::STATUS_W-1:0] symmetry_verdict();
      int unsigned n, r, e, s, col, beg_p, end_p, cb, ce;
      bit found;
      n = rows_cfg;
      if (pat_count > DEPTH) return sps_pkg::ST_BAD;
      if (pat_count < n + 1) return sps_pkg::ST_BAD;
      for (r = 0; r <= n; r++) begin
         if (pat_store[r] > pat_count) return sps_pkg::ST_BAD;
         if (r > 0 && pat_store[r] < pat_store[r-1]) return sps_pkg::ST_BAD;
      end
      for (r = 0; r < n; r++) begin
         beg_p = pat_store[r];
         end_p = pat_store[r+1];
         for (e = beg_p; e < end_p; e++) begin
            col = pat_store[e];
            if (col > r) begin
               if (col >= n) return sps_pkg::ST_BAD;
               cb = pat_store[col];
               ce = pat_store[col+1];
               found = 1'b0;
               for (s = cb; s < ce && !found; s++) begin
                  if (pat_store[s] == r) found = 1'b1;
               end
               if (!found) return sps_pkg::ST_NONSYM;
            end
         end
      end
      return sps_pkg::ST_SYM;
   endfunction

   // Called at a rising edge; returns at the edge where the word was taken.
   task automatic send_word(input logic [sps_pkg::IN_W-1:0] w, input logic last);
      int gap;
      gap = send_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_index_word <= w;
      req_last_word  <= last;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (pat_count < DEPTH) begin
         pat_store[pat_count] = w;
         pat_count++;
      end else begin
         pat_count = DEPTH + 1;
      end
      if (last) begin
         status_q.push_back(symmetry_verdict());
         pat_count = 0;
         loads_sent++;
      end
   endtask

   task automatic send_load();
      foreach (load_q[i]) send_word(load_q[i], i == load_q.size() - 1);
   endtask

   // Sender goes quiet until every outstanding status is back, then a short tail.
   task automatic drain_results(input int tail);
      int waited;
      req_valid <= 1'b0;
      for (waited = 0; status_q.size() != 0 && waited < DRAIN_LIMIT; waited++)
         @(posedge clock);
      if (status_q.size() != 0) begin
         $display("%0t: %0d expected statuses never arrived", $time, status_q.size());
         err_count++;
         status_q.delete();
      end
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_rows(input logic [sps_pkg::ROWS_W-1:0] n);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rows_cfg = n;
      row_writes++;
   endtask

   // Builds an index array for n rows from a random symmetric link matrix, then
   // damages it according to kind.
   task automatic build_load(input int n, input load_kind_type kind);
      int i, j, k, ptr, edges;
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++) link[i][j] = 1'b0;
      edges = (n == 0) ? 0 : $urandom_range(0, 2 * n);
      repeat (edges) begin
         i = $urandom_range(0, n - 1);
         j = $urandom_range(0, n - 1);
         link[i][j] = 1'b1;
         link[j][i] = 1'b1;
      end
      if (kind == LD_ASYM && n >= 2) begin
         i = $urandom_range(0, n - 1);
         j = (i + $urandom_range(1, n - 1)) % n;
         link[i][j] = 1'b1;
         link[j][i] = 1'b0;
      end
      load_q.delete();
      ptr = n + 1;
      for (i = 0; i <= n; i++) begin
         load_q.push_back(16'(ptr));
         if (i < n)
            for (j = 0; j < n; j++) ptr += link[i][j];
      end
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++)
            if (link[i][j]) load_q.push_back(16'(j));
      case (kind)
         LD_SYM: begin
            // trailing words past the last pointer are never walked
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 4)) load_q.push_back(16'($urandom));
         end
         LD_COL_RANGE: begin
            if (load_q.size() > n + 1) begin
               k = $urandom_range(n + 1, load_q.size() - 1);
               load_q[k] = 16'($urandom_range(n, 16'hFFFF));
            end
         end
         LD_PTR_DEC: begin
            if (n >= 1) begin
               k = $urandom_range(1, n);
               load_q[k] = load_q[k-1] - 16'($urandom_range(1, load_q[k-1]));
            end
         end
         LD_PTR_PAST: begin
            k = $urandom_range(0, n);
            load_q[k] = 16'($urandom_range(load_q.size() + 1, 16'hFFFF));
         end
         LD_SHORT: begin
            if (n >= 1) begin
               k = $urandom_range(1, n);
               while (load_q.size() > k) void'(load_q.pop_back());
            end
         end
         LD_NOISE: begin
            load_q.delete();
            repeat ($urandom_range(1, 24)) begin
               if ($urandom_range(0, 3) == 0) load_q.push_back(16'($urandom));
               else load_q.push_back(16'($urandom_range(0, n + 8)));
            end
         end
         default: ;
      endcase
   endtask

   // Result side: check each transaction, then draw the next stall.
   initial begin : rsp_side
      int wait_left;
      logic [sps_pkg::STATUS_W-1:0] want;
      wait_left = $urandom_range(0, 15);
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               $display("%0t: status %0d with nothing expected", $time, rsp_status);
               err_count++;
            end else begin
               want = status_q.pop_front();
               seen_by_status[want]++;
               if (rsp_status !== want) begin
                  $display("%0t: status mismatch, expected %0d got %0d",
                           $time, want, rsp_status);
                  err_count++;
               end
            end
            wait_left = recv_idle ? $urandom_range(0, 15) : 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Reset value of row_count is 1, so nothing is written first.
   task automatic test_reset_rows();
      load_q = '{16'd2, 16'd3, 16'hFFFF};   // column beyond the single row
      send_load();
      load_q = '{16'd2, 16'd3, 16'h0000};   // diagonal entry is skipped
      send_load();
      drain_results(TAIL_CYCLES);
   endtask

   task automatic test_zero_rows();
      write_rows(12'd0);
      load_q = '{16'd1};
      send_load();
      load_q = '{16'h8000};                 // pointer past the load
      send_load();
      drain_results(TAIL_CYCLES);
   endtask

   task automatic test_small_cases();
      write_rows(12'd3);
      load_q = '{16'd4, 16'd5, 16'd7, 16'd8, 16'd1, 16'd0, 16'd2, 16'd1};
      send_load();
      // row 1 lacks the mirror of (0,1) before its out-of-range column is seen
      load_q = '{16'd4, 16'd5, 16'd6, 16'd6, 16'd1, 16'd3};
      send_load();
      load_q = '{16'd4, 16'd3, 16'd4, 16'd4};  // decreasing pointers
      send_load();
      load_q = '{16'd4, 16'd4};                // fewer words than pointers
      send_load();
      drain_results(TAIL_CYCLES);
   endtask

   task automatic test_store_overrun();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      write_rows(12'd2);
      load_q = '{16'd3, 16'd3, 16'd3};
      while (load_q.size() < DEPTH + 4) load_q.push_back(16'($urandom));
      send_load();
      drain_results(TAIL_CYCLES);
   endtask

   task automatic test_widest_rows();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      write_rows(12'd4095);
      load_q.delete();
      repeat (DEPTH) load_q.push_back(16'(DEPTH));   // every row empty, store full
      send_load();
      load_q = '{16'(DEPTH)};
      send_load();
      drain_results(TAIL_CYCLES);
   endtask

   // Receiver holds off long enough that the block must stall its input.
   task automatic test_backpressure();
      send_idle = 1'b0;
      recv_idle = 1'b1;
      write_rows(12'd4);
      hold_left = 400;
      repeat (8) begin
         build_load(4, LD_SYM);
         send_load();
      end
      drain_results(TAIL_CYCLES);
   endtask

   task automatic test_random_patterns();
      int start_words, n, roll;
      load_kind_type kind;
      start_words = words_sent;
      while (words_sent - start_words < RANDOM_WORDS) begin
         roll = $urandom_range(0, 19);
         if (roll == 0) n = 0;
         else if (roll == 1) n = $urandom_range(13, 48);
         else n = $urandom_range(1, 12);
         write_rows(12'(n));
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 6)) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) kind = LD_SYM;
            else if (roll < 65) kind = LD_ASYM;
            else if (roll < 73) kind = LD_COL_RANGE;
            else if (roll < 80) kind = LD_PTR_DEC;
            else if (roll < 87) kind = LD_PTR_PAST;
            else if (roll < 92) kind = LD_SHORT;
            else kind = LD_NOISE;
            build_load(n, kind);
            send_load();
         end
         drain_results(TAIL_CYCLES);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_valid      <= 1'b0;
      req_index_word <= '0;
      req_last_word  <= 1'b0;
      rows_cfg   = 12'd1;
      pat_count  = 0;
      send_idle  = 1'b1;
      recv_idle  = 1'b1;
      hold_left  = 0;
      err_count  = 0;
      words_sent = 0;
      loads_sent = 0;
      row_writes = 0;
      foreach (seen_by_status[i]) seen_by_status[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_rows();
      test_zero_rows();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      test_small_cases();
      test_store_overrun();
      test_widest_rows();
      test_backpressure();
      test_random_patterns();

      drain_results(TAIL_CYCLES);
      $display("covered %0d index words in %0d arrays over %0d row_count settings",
               words_sent, loads_sent, row_writes);
      $display("statuses checked: %0d symmetric, %0d not symmetric, %0d malformed",
               seen_by_status[sps_pkg::ST_SYM], seen_by_status[sps_pkg::ST_NONSYM],
               seen_by_status[sps_pkg::ST_BAD]);
      if (err_count == 0) begin
         $display("tb_sparse_pattern_symmetry_check_top: done, clean");
      end else begin
         $display("tb_sparse_pattern_symmetry_check_top: done, errors");
      end
      $finish;
   end

endmodule
